@@ hdl/ptt_pkg.sv @@
// shared constants, codes and types of the periodic timer table
package ptt_pkg;

  localparam int NumTimers  = 16;
  localparam int TimeBits   = 32;
  localparam int MaxResults = 16;
  localparam int IdxW       = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int CntW       = $clog2(MaxResults + 1);

  localparam int ReqW     = 3;
  localparam int SlotW    = 4;
  localparam int PeriodW  = 32;
  localparam int OwnerW   = 8;
  localparam int EventW   = 16;
  localparam int StepW    = 16;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 64;
  localparam int OutDataW = 32;

  localparam logic [StepW-1:0] TickStepRst = StepW'(10);

  localparam logic [CfgIdxW-1:0] CfgTickStep = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSuppress = 1'b1;

  typedef enum logic [ReqW-1:0] {
    ReqTick,
    ReqCreate,
    ReqKill,
    ReqReset,
    ReqPause,
    ReqResume,
    ReqChange,
    ReqQuery
  } req_e;

  typedef struct packed {
    logic              kind;
    logic              ok;
    logic [SlotW-1:0]  slot;
    logic [OwnerW-1:0] owner;
    logic [EventW-1:0] evt;
    logic              valid;
    logic              paused;
    logic              last;
  } ptt_res_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic scan_start;
    logic scan_sel;
    logic scan_step;
    logic flush;
  } ptt_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_last;
    logic need_emit;
    logic pend_valid;
  } ptt_stat_t;

endpackage

@@ hdl/ptt_ctrl.sv @@
// request sequencer of the periodic timer table
module ptt_ctrl import ptt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic [ReqW-1:0] req_type_i,
  output logic            req_ready_o,
  input  ptt_stat_t       stat_i,
  output ptt_cmd_t        cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StExec  = 2'd1;
  localparam logic [1:0] StScan  = 2'd2;
  localparam logic [1:0] StFlush = 2'd3;

  logic [1:0] state_q, state_d;
  logic       is_tick;

  assign is_tick     = (req_e'(req_type_i) == ReqTick);
  assign req_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          cmd_o.latch = 1'b1;
          if (is_tick) begin
            cmd_o.scan_start = 1'b1;
            state_d          = StScan;
          end else begin
            state_d = StExec;
          end
        end
      end
      StExec: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = StIdle;
        end
      end
      StScan: begin
        cmd_o.scan_sel = 1'b1;
        // hold the scan while an earlier expiry cannot leave yet
        if (!(stat_i.need_emit && !stat_i.out_free)) begin
          cmd_o.scan_step = 1'b1;
          if (stat_i.scan_last) begin
            state_d = StFlush;
          end
        end
      end
      StFlush: begin
        if (!stat_i.pend_valid) begin
          state_d = StIdle;
        end else if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/ptt_dp.sv @@
// timer table storage, command execution, tick scan and result register
module ptt_dp import ptt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ptt_cmd_t            cmd_i,
  output ptt_stat_t           stat_o,
  input  logic [ReqW-1:0]     req_type_i,
  input  logic [SlotW-1:0]    timer_id_i,
  input  logic [PeriodW-1:0]  period_ms_i,
  input  logic [OwnerW-1:0]   owner_tag_i,
  input  logic [EventW-1:0]   event_tag_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output ptt_res_t            res_o
);

  // configuration
  logic [StepW-1:0] step_q;
  logic             sup_q;

  // captured request
  req_e               req_q;
  logic [SlotW-1:0]   id_q;
  logic [TimeBits-1:0] period_q;
  logic [OwnerW-1:0]  owner_q;
  logic [EventW-1:0]  event_q;

  // timer table
  logic [NumTimers-1:0] used_q;
  logic [NumTimers-1:0] run_q;
  logic [TimeBits-1:0]  rem_q [NumTimers];
  logic [TimeBits-1:0]  per_q [NumTimers];
  logic [OwnerW-1:0]    own_q [NumTimers];
  logic [EventW-1:0]    evt_q [NumTimers];

  // scan state
  logic [IdxW-1:0]   scan_idx_q;
  logic [CntW-1:0]   cnt_q;
  logic              pend_v_q;
  logic [SlotW-1:0]  pend_slot_q;
  logic [OwnerW-1:0] pend_own_q;
  logic [EventW-1:0] pend_evt_q;

  // result register
  ptt_res_t out_q;
  logic     out_v_q;

  logic [IdxW-1:0]     id_idx, rd_idx, free_idx, wr_idx;
  logic                free_found, id_ok;
  logic [TimeBits-1:0] rem_rd, per_rd, rem_val, step_ext;
  logic [OwnerW-1:0]   own_rd;
  logic [EventW-1:0]   evt_rd;
  logic                run_rd;
  logic                used_set, used_clr, run_wr, run_val, rem_wr, per_wr, tag_wr;
  logic                hit, gt, expire, out_free, out_load;
  ptt_res_t            rep, pend_res, out_next;

  assign id_idx   = IdxW'(id_q);
  assign rd_idx   = cmd_i.scan_sel ? scan_idx_q : id_idx;
  assign rem_rd   = rem_q[rd_idx];
  assign per_rd   = per_q[rd_idx];
  assign own_rd   = own_q[rd_idx];
  assign evt_rd   = evt_q[rd_idx];
  assign run_rd   = run_q[rd_idx];
  assign step_ext = TimeBits'(step_q);
  assign id_ok    = (int'(id_q) < NumTimers) && used_q[id_idx];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NumTimers - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = IdxW'(i);
      end
    end
  end

  // command execution and reply
  always_comb begin
    rep      = '0;
    rep.last = 1'b1;
    wr_idx   = id_idx;
    used_set = 1'b0;
    used_clr = 1'b0;
    run_wr   = 1'b0;
    run_val  = 1'b0;
    rem_wr   = 1'b0;
    rem_val  = per_rd;
    per_wr   = 1'b0;
    tag_wr   = 1'b0;
    case (req_q)
      ReqCreate: begin
        if (free_found) begin
          wr_idx    = free_idx;
          used_set  = 1'b1;
          run_wr    = 1'b1;
          run_val   = 1'b1;
          rem_wr    = 1'b1;
          rem_val   = period_q;
          per_wr    = 1'b1;
          tag_wr    = 1'b1;
          rep.ok    = 1'b1;
          rep.slot  = SlotW'(free_idx);
          rep.owner = owner_q;
          rep.evt   = event_q;
        end
      end
      default: begin
        rep.slot = id_q;
        if (id_ok) begin
          rep.owner = own_rd;
          rep.evt   = evt_rd;
          case (req_q)
            ReqKill: begin
              rep.ok   = 1'b1;
              used_clr = 1'b1;
              run_wr   = 1'b1;
            end
            ReqReset: begin
              rep.ok  = 1'b1;
              rem_wr  = 1'b1;
              run_wr  = 1'b1;
              run_val = 1'b1;
            end
            ReqPause: begin
              if (run_rd) begin
                rep.ok = 1'b1;
                run_wr = 1'b1;
              end
            end
            ReqResume: begin
              if (!run_rd) begin
                rep.ok  = 1'b1;
                run_wr  = 1'b1;
                run_val = 1'b1;
              end
            end
            ReqChange: begin
              rep.ok  = 1'b1;
              rem_wr  = 1'b1;
              rem_val = period_q;
              per_wr  = 1'b1;
            end
            ReqQuery: begin
              rep.ok     = 1'b1;
              rep.valid  = 1'b1;
              rep.paused = !run_rd;
            end
            default: begin
            end
          endcase
        end
      end
    endcase
  end

  // one slot of the tick scan
  assign hit    = used_q[scan_idx_q] && run_q[scan_idx_q];
  assign gt     = rem_rd > step_ext;
  assign expire = hit && !gt && !sup_q && (int'(cnt_q) < MaxResults);

  always_comb begin
    pend_res       = '0;
    pend_res.kind  = 1'b1;
    pend_res.ok    = 1'b1;
    pend_res.slot  = pend_slot_q;
    pend_res.owner = pend_own_q;
    pend_res.evt   = pend_evt_q;
    pend_res.last  = cmd_i.flush;
  end

  assign out_free = !out_v_q || res_ready_i;
  assign out_load = cmd_i.exec || cmd_i.flush || (cmd_i.scan_step && expire && pend_v_q);
  assign out_next = cmd_i.exec ? rep : pend_res;

  assign stat_o.out_free   = out_free;
  assign stat_o.scan_last  = (int'(scan_idx_q) == NumTimers - 1);
  assign stat_o.need_emit  = expire && pend_v_q;
  assign stat_o.pend_valid = pend_v_q;

  assign res_valid_o = out_v_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= TickStepRst;
      sup_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTickStep: step_q <= cfg_data_i[StepW-1:0];
        CfgSuppress: sup_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q    <= req_e'(req_type_i);
      id_q     <= timer_id_i;
      period_q <= TimeBits'(period_ms_i);
      owner_q  <= owner_tag_i;
      event_q  <= event_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      run_q  <= '0;
    end else if (cmd_i.exec) begin
      if (used_set) used_q[wr_idx] <= 1'b1;
      if (used_clr) used_q[wr_idx] <= 1'b0;
      if (run_wr)   run_q[wr_idx]  <= run_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (rem_wr) rem_q[wr_idx] <= rem_val;
      if (per_wr) per_q[wr_idx] <= period_q;
      if (tag_wr) begin
        own_q[wr_idx] <= owner_q;
        evt_q[wr_idx] <= event_q;
      end
    end else if (cmd_i.scan_step && hit) begin
      rem_q[scan_idx_q] <= gt ? (rem_rd - step_ext) : per_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      cnt_q      <= '0;
      pend_v_q   <= 1'b0;
    end else if (cmd_i.scan_start) begin
      scan_idx_q <= '0;
      cnt_q      <= '0;
      pend_v_q   <= 1'b0;
    end else if (cmd_i.scan_step) begin
      scan_idx_q <= scan_idx_q + IdxW'(1);
      if (expire) begin
        cnt_q    <= cnt_q + CntW'(1);
        pend_v_q <= 1'b1;
      end
    end else if (cmd_i.flush) begin
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step && expire) begin
      pend_slot_q <= SlotW'(scan_idx_q);
      pend_own_q  <= own_rd;
      pend_evt_q  <= evt_rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (res_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_next;
    end
  end

endmodule

@@ hdl/periodic_timer_table_top.sv @@
// periodic timer table top level
// A table of 16 cyclic timers driven by one request at a time. Every request
// other than a tick gives one reply (tuser 0, tlast 1), loaded into the reply
// register from the execute state once no earlier result still waits on the
// output; the next request can be taken after that. A tick walks the table
// one slot per cycle while the walk is not stalled, then flushes any held
// final expiry before the next request is taken. It gives one expiry result
// (tuser 1) per timer that runs out, the final one marked by tlast, and none
// when nothing expires or expiries are suppressed by configuration. The slot
// walk stalls only while a further expiry is found and an earlier result
// still occupies the output register. The input is taken only between requests;
// a finished result waiting on the output does not block the next request.
module periodic_timer_table_top import ptt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // timer_id, period_ms, owner_tag, event_tag, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // req_type
  input  logic [ReqW-1:0]     s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // ok, slot, owner_out, event_out, is_valid, is_paused, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // result_kind
  output logic                m_axis_tuser,
  output logic                m_axis_tlast,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ptt_cmd_t  cmd;
  ptt_stat_t stat;
  ptt_res_t  res;

  ptt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_type_i  (s_axis_tuser),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ptt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_type_i  (s_axis_tuser),
    .timer_id_i  (s_axis_tdata[3:0]),
    .period_ms_i (s_axis_tdata[35:4]),
    .owner_tag_i (s_axis_tdata[43:36]),
    .event_tag_i (s_axis_tdata[59:44]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {1'b0, res.paused, res.valid, res.evt, res.owner, res.slot, res.ok};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

@@ hdl/ptt_checker.sv @@
// port checks of the periodic timer table and their binding
module ptt_checker import ptt_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser,
  input logic                m_axis_tlast
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // command replies are single results
  a_reply_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
    else $error("reply without last");

  // expiries carry ok and no query flags
  a_expiry_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[0] && !m_axis_tdata[29] && !m_axis_tdata[30])
    else $error("bad expiry fields");

  // paused only for a slot in use
  a_paused_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[30] |-> m_axis_tdata[29])
    else $error("paused without valid");

endmodule

bind periodic_timer_table_top ptt_checker u_ptt_checker (.*);
